// ----- src/lse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// types, codes and constants shared by the line splitter modules
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw  = $clog2(FifoDepth);

  localparam logic [ByteW-1:0] CharLf = 8'h0A;
  localparam logic [ByteW-1:0] CharCr = 8'h0D;

  // input commands
  localparam logic CmdData = 1'b0;
  localparam logic CmdEos  = 1'b1;

  // register indexes
  localparam logic [1:0] RegEolMode    = 2'd0;
  localparam logic [1:0] RegIncludeEol = 2'd1;
  localparam logic [1:0] RegDropIncomp = 2'd2;

  typedef enum logic [CodeW-1:0] {
    ModeAuto  = 2'd0,
    ModeCrlf  = 2'd1,
    ModeLf    = 2'd2,
    ModeMixed = 2'd3
  } eol_mode_e;

  // line status codes
  localparam logic [CodeW-1:0] StatEol     = 2'd0;
  localparam logic [CodeW-1:0] StatKept    = 2'd1;
  localparam logic [CodeW-1:0] StatDiscard = 2'd2;

  // terminator kinds, also auto lock codes
  localparam logic [CodeW-1:0] KindNone = 2'd0;
  localparam logic [CodeW-1:0] KindLf   = 2'd1;
  localparam logic [CodeW-1:0] KindCrlf = 2'd2;

  typedef struct packed {
    eol_mode_e eol_mode;
    logic      include_eol;
    logic      drop_incomplete;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             line_end;
    logic [CodeW-1:0] line_status;
    logic [CodeW-1:0] eol_kind;
  } word_t;

  // one classified input item: one or two output words
  typedef struct packed {
    logic  two;
    word_t w0;
    word_t w1;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/lse_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_in_if
// input channel: command and stream byte with valid/ready
// ----------------------------------------------------------------------------
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- src/lse_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_out_if
// output channel: line content words with valid/ready
// ----------------------------------------------------------------------------
interface lse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       line_end;
  logic [1:0] line_status;
  logic [1:0] eol_kind;

  modport source (output valid, output out_byte, output byte_valid, output line_end,
                  output line_status, output eol_kind, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input line_end,
                  input line_status, input eol_kind, output ready);
endinterface
`default_nettype wire

// ----- src/lse_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_front
// accepts input items, tracks held cr / open line / auto lock, and turns
// each item into zero, one or two output words for the queue
// ----------------------------------------------------------------------------
module lse_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  lse_pkg::cfg_t    cfg_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire              command_i,
  input  wire  [7:0]       data_byte_i,
  input  wire              full_i,
  output logic             push_o,
  output lse_pkg::entry_t  push_entry_o
);
  import lse_pkg::*;

  logic             cr_held_q, cr_held_d;
  logic             line_open_q, line_open_d;
  logic [CodeW-1:0] lock_q, lock_d;
  logic             crlf_ok, lf_ok, accept;
  logic [1:0]       n_words;
  word_t            w0, w1, eol_word, plain_word;
  logic             plain_emit, plain_is_end;
  logic [CodeW-1:0] part_stat;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign crlf_ok = (cfg_i.eol_mode == ModeCrlf) || (cfg_i.eol_mode == ModeMixed) ||
                   ((cfg_i.eol_mode == ModeAuto) && (lock_q != KindLf));
  assign lf_ok   = (cfg_i.eol_mode == ModeLf) || (cfg_i.eol_mode == ModeMixed) ||
                   ((cfg_i.eol_mode == ModeAuto) && (lock_q != KindCrlf));

  assign part_stat = cfg_i.drop_incomplete ? StatDiscard : StatKept;

  always_comb begin
    eol_word             = '0;
    eol_word.out_byte    = cfg_i.include_eol ? CharLf : '0;
    eol_word.byte_valid  = cfg_i.include_eol;
    eol_word.line_end    = 1'b1;
    eol_word.line_status = StatEol;
  end

  always_comb begin
    cr_held_d    = cr_held_q;
    line_open_d  = line_open_q;
    lock_d       = lock_q;
    n_words      = 2'd0;
    w0           = '0;
    w1           = '0;
    plain_emit   = 1'b0;
    plain_is_end = 1'b0;
    plain_word   = '0;
    if (command_i == CmdEos) begin
      cr_held_d   = 1'b0;
      line_open_d = 1'b0;
      if (cr_held_q) begin
        w0 = '{out_byte: CharCr, byte_valid: 1'b1, line_end: 1'b1,
               line_status: part_stat, eol_kind: KindNone};
        n_words = 2'd1;
      end else if (line_open_q) begin
        w0 = '{out_byte: '0, byte_valid: 1'b0, line_end: 1'b1,
               line_status: part_stat, eol_kind: KindNone};
        n_words = 2'd1;
      end
    end else if (cr_held_q && (data_byte_i == CharLf) && crlf_ok) begin
      cr_held_d   = 1'b0;
      line_open_d = 1'b0;
      if (cfg_i.eol_mode == ModeAuto && lock_q == KindNone) begin
        lock_d = KindCrlf;
      end
      if (cfg_i.include_eol) begin
        w0 = '{out_byte: CharCr, byte_valid: 1'b1, line_end: 1'b0,
               line_status: StatEol, eol_kind: KindNone};
        w1 = eol_word;
        w1.eol_kind = KindCrlf;
        n_words = 2'd2;
      end else begin
        w0 = eol_word;
        w0.eol_kind = KindCrlf;
        n_words = 2'd1;
      end
    end else begin
      // lone held cr becomes content, then the byte is handled plainly
      cr_held_d = 1'b0;
      if (data_byte_i == CharCr && crlf_ok) begin
        cr_held_d = 1'b1;
      end else if (data_byte_i == CharLf && lf_ok) begin
        plain_emit   = 1'b1;
        plain_is_end = 1'b1;
        plain_word   = eol_word;
        plain_word.eol_kind = KindLf;
        line_open_d  = 1'b0;
        if (cfg_i.eol_mode == ModeAuto && lock_q == KindNone) begin
          lock_d = KindLf;
        end
      end else begin
        plain_emit  = 1'b1;
        plain_word  = '{out_byte: data_byte_i, byte_valid: 1'b1, line_end: 1'b0,
                        line_status: StatEol, eol_kind: KindNone};
        line_open_d = 1'b1;
      end
      if (cr_held_q) begin
        w0 = '{out_byte: CharCr, byte_valid: 1'b1, line_end: 1'b0,
               line_status: StatEol, eol_kind: KindNone};
        if (!plain_is_end) begin
          line_open_d = 1'b1;
        end
        w1      = plain_word;
        n_words = plain_emit ? 2'd2 : 2'd1;
      end else begin
        w0      = plain_word;
        n_words = plain_emit ? 2'd1 : 2'd0;
      end
    end
  end

  assign push_o       = accept && (n_words != 2'd0);
  assign push_entry_o = '{two: (n_words == 2'd2), w0: w0, w1: w1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_held_q   <= 1'b0;
      line_open_q <= 1'b0;
      lock_q      <= KindNone;
    end else if (accept) begin
      cr_held_q   <= cr_held_d;
      line_open_q <= line_open_d;
      lock_q      <= lock_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/lse_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module lse_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  lse_pkg::entry_t  push_entry_i,
  output logic             full_o,
  input  wire              pop_i,
  output lse_pkg::entry_t  head_o,
  output logic             empty_o
);
  import lse_pkg::*;

  entry_t              mem_q [FifoDepth];
  logic [FifoAw-1:0]   wptr_q, rptr_q;
  logic [FifoAw:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + FifoAw'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + FifoAw'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (FifoAw+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (FifoAw+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/lse_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_back
// expands queued items into output words, one word per cycle while out_o is
// ready, through an output register
// ----------------------------------------------------------------------------
module lse_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  lse_pkg::entry_t  head_i,
  input  wire              empty_i,
  output logic             pop_o,
  lse_out_if.source        out_o
);
  import lse_pkg::*;

  logic  out_valid_q;
  word_t out_word_q;
  logic  sel_q;
  logic  load, last;
  word_t next_word;

  assign load      = !empty_i && (!out_valid_q || out_o.ready);
  assign last      = !head_i.two || sel_q;
  assign next_word = sel_q ? head_i.w1 : head_i.w0;
  assign pop_o     = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sel_q       <= !last;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= next_word;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_word_q.out_byte;
  assign out_o.byte_valid  = out_word_q.byte_valid;
  assign out_o.line_end    = out_word_q.line_end;
  assign out_o.line_status = out_word_q.line_status;
  assign out_o.eol_kind    = out_word_q.eol_kind;

endmodule
`default_nettype wire

// ----- src/line_splitter_eol_modes.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_splitter_eol_modes
// splits a byte stream into lines with lf, crlf, mixed or auto end of line
//
//   channel   dir  payload                                          handshake
//   in_i      in   command, data_byte                               valid/ready
//   out_o     out  out_byte, byte_valid, line_end, line_status,     valid/ready
//                  eol_kind
//   apb       in   eol_mode, include_eol, drop_incomplete at 0/4/8  psel/penable
//
// one input word per cycle unless the queue is full; an item yields zero to
// two output words; the back end sends one word per cycle while out_o is ready
// first output word goes through a queue entry and then the output register
// a 4-entry queue between front and back absorbs output stalls; the input
// stalls only when that queue is full
// reset clears all line state and the auto lock; no clearing pass
// ----------------------------------------------------------------------------
module line_splitter_eol_modes (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [lse_pkg::AddrW-1:0] paddr,
  input  wire  [lse_pkg::DataW-1:0] pwdata,
  output logic [lse_pkg::DataW-1:0] prdata,
  output logic                pready,
  lse_in_if.sink              in_i,
  lse_out_if.source           out_o
);
  import lse_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       full, empty, push, pop;
  entry_t     push_entry, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{eol_mode: ModeAuto, include_eol: 1'b0, drop_incomplete: 1'b0};
    end else if (wr_en) begin
      case (reg_idx)
        RegEolMode:    cfg_q.eol_mode        <= eol_mode_e'(pwdata[1:0]);
        RegIncludeEol: cfg_q.include_eol     <= pwdata[0];
        RegDropIncomp: cfg_q.drop_incomplete <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegEolMode:    prdata = DataW'(cfg_q.eol_mode);
      RegIncludeEol: prdata = DataW'(cfg_q.include_eol);
      RegDropIncomp: prdata = DataW'(cfg_q.drop_incomplete);
      default:       prdata = '0;
    endcase
  end

  lse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .command_i    (in_i.command),
    .data_byte_i  (in_i.data_byte),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  lse_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  lse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
